// ----- rtl/deq_pkg.sv -----
`timescale 1ns / 1ps

package deq_pkg;

    // Default sizes and the fixed width of the word fields
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int OPCODE_WIDTH   = 2;

    // Opcodes
    localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OPCODE_WIDTH-1:0] OP_POP_BACK   = 2'd3;

    // Command item
    typedef struct packed {
        logic [OPCODE_WIDTH-1:0]       opcode;
        logic signed [FIELD_WIDTH-1:0] data_in;
    } deq_in_t;

    // Result item
    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] data_out;
        logic                          success;
        logic                          empty_flag;
        logic                          full_flag;
    } deq_out_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_right;  // push front: every word moves one cell back
        logic shift_left;   // pop front: every word moves one cell forward
        logic append;       // push back: first empty cell takes the word
        logic grab;         // pop back: last valid cell hands its word to the lane
    } deq_ctrl_t;

endpackage

// ----- rtl/deq_cell.sv -----
`timescale 1ns / 1ps

module deq_cell #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  deq_pkg::deq_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic                  left_valid,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  right_valid,
    input  logic [DATA_WIDTH-1:0] right_lane_data,
    input  logic                  right_lane_valid,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  valid,
    output logic [DATA_WIDTH-1:0] lane_data,
    output logic                  lane_valid
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] lane_data_reg;
    logic [DATA_WIDTH-1:0] lane_data_next;
    logic                  lane_valid_reg;
    logic                  lane_valid_next;

    // Update the stored word and the return lane
    always_comb
    begin
        data_next       = data_reg;
        valid_next      = valid_reg;
        lane_data_next  = right_lane_data;
        lane_valid_next = right_lane_valid;
        if (ctrl.shift_right)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.shift_left)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.append)
        begin
            if (!valid_reg && left_valid)
            begin
                data_next  = word;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.grab)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next      = 1'b0;
                lane_data_next  = data_reg;
                lane_valid_next = 1'b1;
            end
        end
    end

    // Hold control bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            lane_valid_reg <= lane_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        lane_data_reg <= lane_data_next;
    end

    assign data       = data_reg;
    assign valid      = valid_reg;
    assign lane_data  = lane_data_reg;
    assign lane_valid = lane_valid_reg;

endmodule

// ----- rtl/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
// Double-ended queue of DATA_WIDTH-bit words, DEPTH entries, built as a row of cells.
// Command channel: cmd (opcode, data_in) is taken at a rising edge with start high
// and busy low. Result channel: done is high for exactly one cycle and result then
// holds data_out, success and the empty and full flags after the operation.
// The receiver cannot stall; every result is taken in the cycle it is shown.
// Word i of the queue sits in cell i, so the front is always cell 0.
// Push front, push back, pop front, and any failed operation: done in the cycle after
// the command is taken, busy stays low, and a new command may follow every cycle.
// Pop back of a queue holding n items: the last valid cell loads its word onto a return
// lane that moves one cell toward cell 0 per cycle, so done comes once the word has
// reached cell 0 and busy stays high until then; the lane length sets the wait.
// Reset empties the queue (all cell valid bits clear) and drops any pending pop.
// A push into a full queue and a pop from an empty one leave the queue unchanged
// and report success low; a failed pop returns zero.
module double_ended_queue_top #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::deq_in_t  cmd,
    output logic              done,
    output deq_pkg::deq_out_t result
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
    logic                  cell_valid [DEPTH];
    logic [DATA_WIDTH-1:0] lane_data  [DEPTH];
    logic                  lane_valid [DEPTH];
    logic [DATA_WIDTH-1:0] word;
    deq_ctrl_t             ctrl;
    logic                  accept;
    logic                  is_full;
    logic                  is_empty;

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   success_reg;
    logic                   success_next;
    logic [FIELD_WIDTH-1:0] data_out_reg;
    logic [FIELD_WIDTH-1:0] data_out_next;

    assign accept   = start && !busy_reg;
    assign word     = DATA_WIDTH'($unsigned(cmd.data_in));
    assign is_empty = !cell_valid[0];
    assign is_full  = cell_valid[DEPTH-1];

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] l_data;
        logic                  l_valid;
        logic [DATA_WIDTH-1:0] r_data;
        logic                  r_valid;
        logic [DATA_WIDTH-1:0] r_lane_data;
        logic                  r_lane_valid;

        if (i == 0)
        begin : g_front
            assign l_data  = word;
            assign l_valid = 1'b1;
        end
        else
        begin : g_inner_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign r_data       = '0;
            assign r_valid      = 1'b0;
            assign r_lane_data  = '0;
            assign r_lane_valid = 1'b0;
        end
        else
        begin : g_inner_r
            assign r_data       = cell_data[i+1];
            assign r_valid      = cell_valid[i+1];
            assign r_lane_data  = lane_data[i+1];
            assign r_lane_valid = lane_valid[i+1];
        end

        deq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (ctrl),
            .word            (word),
            .left_data       (l_data),
            .left_valid      (l_valid),
            .right_data      (r_data),
            .right_valid     (r_valid),
            .right_lane_data (r_lane_data),
            .right_lane_valid(r_lane_valid),
            .data            (cell_data[i]),
            .valid           (cell_valid[i]),
            .lane_data       (lane_data[i]),
            .lane_valid      (lane_valid[i])
        );
    end

    // Decode the command and build the result
    always_comb
    begin
        ctrl          = '0;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        success_next  = 1'b0;
        data_out_next = '0;
        if (accept)
        begin
            unique case (cmd.opcode)
                OP_PUSH_FRONT:
                begin
                    ctrl.shift_right = !is_full;
                    done_next        = 1'b1;
                    success_next     = !is_full;
                end
                OP_PUSH_BACK:
                begin
                    ctrl.append  = !is_full;
                    done_next    = 1'b1;
                    success_next = !is_full;
                end
                OP_POP_FRONT:
                begin
                    ctrl.shift_left = !is_empty;
                    done_next       = 1'b1;
                    success_next    = !is_empty;
                    if (!is_empty)
                    begin
                        data_out_next = FIELD_WIDTH'(cell_data[0]);
                    end
                end
                default:
                begin
                    // Pop back: start the lane, or fail at once when empty
                    if (is_empty)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.grab = 1'b1;
                        busy_next = 1'b1;
                    end
                end
            endcase
        end
        else if (busy_reg && lane_valid[0])
        begin
            // Lane word has reached the front cell
            busy_next     = 1'b0;
            done_next     = 1'b1;
            success_next  = 1'b1;
            data_out_next = FIELD_WIDTH'(lane_data[0]);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        success_reg  <= success_next;
        data_out_reg <= data_out_next;
    end

    assign busy              = busy_reg;
    assign done              = done_reg;
    assign result.data_out   = data_out_reg;
    assign result.success    = success_reg;
    assign result.empty_flag = is_empty;
    assign result.full_flag  = is_full;

endmodule

// ----- rtl/deq_checker.sv -----
`timescale 1ns / 1ps

module deq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input deq_pkg::deq_in_t  cmd,
    input logic              done,
    input deq_pkg::deq_out_t result
);
    import deq_pkg::*;

    // Queue cannot be empty and full at once
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.empty_flag && result.full_flag))
        else $error("empty and full flags both set");

    // Failed operation returns zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.success) |-> (result.data_out == '0))
        else $error("failed item returned nonzero data");

    // Every command but pop back answers in the next cycle
    a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode != OP_POP_BACK)) |=> done)
        else $error("missing result one cycle after command");

    // Result never shows while a pop is still in flight
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
);

// ----- tb/double_ended_queue_top_test.sv -----
`timescale 1ns / 1ps

module double_ended_queue_top_test;

    import deq_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;
    localparam int WORD_BITS  = DATA_WIDTH_DEF;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 4 * RING_DEPTH;
    localparam int RAND_ITEMS = 400;

    // One row of stimulus: the command plus an optional hand-typed result
    typedef struct packed {
        deq_in_t  item;
        logic     typed;
        deq_out_t want;
    } cmd_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    deq_in_t  cmd;
    logic     done;
    deq_out_t result;

    // Row fields that travel with the command being offered
    logic     row_typed;
    deq_out_t row_want;

    cmd_row_t rows[$];
    deq_out_t owed_results[$];
    int       err_count = 0;
    int       idle_cycles = 0;

    // Shadow deque: ring contents, front slot, slot after the back, fill level
    logic [63:0] shadow_ring [RING_DEPTH];
    int          front_slot = 0;
    int          tail_slot = 0;
    int          fill_level = 0;

    deq_out_t predicted;
    deq_out_t got;
    deq_out_t owed;

    double_ended_queue_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #1 clk = ~clk;

    function automatic deq_out_t pack_result(logic [31:0] word, logic ok,
                                             logic is_empty, logic is_full);
        deq_out_t r;
        r.data_out   = word;
        r.success    = ok;
        r.empty_flag = is_empty;
        r.full_flag  = is_full;
        return r;
    endfunction

    // Apply one command to the shadow deque and return the result it owes
    function automatic deq_out_t apply_deque_op(deq_in_t item);
        logic [63:0] keep_mask;
        logic [63:0] word;
        logic [63:0] popped;
        logic        ok;
        keep_mask = (WORD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);
        word      = {32'd0, item.data_in} & keep_mask;
        popped    = 64'd0;
        ok        = 1'b0;
        case (item.opcode)
            OP_PUSH_FRONT:
                if (fill_level < RING_DEPTH)
                begin
                    front_slot = (front_slot == 0) ? RING_DEPTH - 1 : front_slot - 1;
                    shadow_ring[front_slot] = word;
                    fill_level++;
                    ok = 1'b1;
                end
            OP_PUSH_BACK:
                if (fill_level < RING_DEPTH)
                begin
                    shadow_ring[tail_slot] = word;
                    tail_slot = (tail_slot + 1) % RING_DEPTH;
                    fill_level++;
                    ok = 1'b1;
                end
            OP_POP_FRONT:
                if (fill_level > 0)
                begin
                    popped = shadow_ring[front_slot];
                    front_slot = (front_slot + 1) % RING_DEPTH;
                    fill_level--;
                    ok = 1'b1;
                end
            default:
                if (fill_level > 0)
                begin
                    tail_slot = (tail_slot == 0) ? RING_DEPTH - 1 : tail_slot - 1;
                    popped = shadow_ring[tail_slot];
                    fill_level--;
                    ok = 1'b1;
                end
        endcase
        return pack_result(popped[31:0], ok, fill_level == 0, fill_level >= RING_DEPTH);
    endfunction

    task automatic add_row(logic [OPCODE_WIDTH-1:0] op, logic [31:0] word,
                           logic typed, deq_out_t want);
        cmd_row_t r;
        r.item.opcode  = op;
        r.item.data_in = word;
        r.typed        = typed;
        r.want         = want;
        rows.push_back(r);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Build the stimulus: directed rows first, then push-heavy, pop-heavy and balanced phases
    task automatic build_rows();
        deq_out_t none;
        int       made;
        int       phase_len;
        int       push_pct;
        none = '0;
        // Pops on the empty queue after reset
        add_row(OP_POP_FRONT, 32'hDEAD_BEEF, 1'b1, pack_result(32'd0, 1'b0, 1'b1, 1'b0));
        add_row(OP_POP_BACK,  32'hFFFF_FFFF, 1'b1, pack_result(32'd0, 1'b0, 1'b1, 1'b0));
        // Extreme words at both ends, then back out
        add_row(OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, pack_result(32'd0, 1'b1, 1'b0, 1'b0));
        add_row(OP_PUSH_FRONT, 32'h8000_0000, 1'b1, pack_result(32'd0, 1'b1, 1'b0, 1'b0));
        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b1,
                pack_result(32'h8000_0000, 1'b1, 1'b0, 1'b0));
        add_row(OP_POP_BACK,   32'h0000_0000, 1'b1,
                pack_result(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0));
        // Fill to the brim from both ends
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            add_row((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, 1'b0, none);
        end
        // Pushes into the full queue drop their word
        add_row(OP_PUSH_BACK,  32'h1234_5678, 1'b1, pack_result(32'd0, 1'b0, 1'b0, 1'b1));
        add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, pack_result(32'd0, 1'b0, 1'b0, 1'b1));
        // Pop back from the full queue takes the longest
        add_row(OP_POP_BACK,  $urandom, 1'b0, none);
        add_row(OP_POP_FRONT, $urandom, 1'b0, none);

        // Random phases; the bias walks the queue between empty and full
        made = 0;
        while (made < RAND_ITEMS)
        begin
            phase_len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            for (int i = 0; i < phase_len && made < RAND_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    add_row($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                            rand_word(), 1'b0, none);
                else
                    add_row($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
                            rand_word(), 1'b0, none);
                made++;
            end
        end
    endtask

    // Check results against the oldest owed one, then log the accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                got = result;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with none owed: data_out %h success %b empty %b full %b",
                             $time, got.data_out, got.success, got.empty_flag, got.full_flag);
                    err_count++;
                end
                else
                begin
                    owed = owed_results.pop_front();
                    if (got.data_out !== owed.data_out)
                    begin
                        $display("%0t: data_out expected %h actual %h",
                                 $time, owed.data_out, got.data_out);
                        err_count++;
                    end
                    if (got.success !== owed.success)
                    begin
                        $display("%0t: success expected %b actual %b",
                                 $time, owed.success, got.success);
                        err_count++;
                    end
                    if (got.empty_flag !== owed.empty_flag)
                    begin
                        $display("%0t: empty_flag expected %b actual %b",
                                 $time, owed.empty_flag, got.empty_flag);
                        err_count++;
                    end
                    if (got.full_flag !== owed.full_flag)
                    begin
                        $display("%0t: full_flag expected %b actual %b",
                                 $time, owed.full_flag, got.full_flag);
                        err_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predicted = apply_deque_op(cmd);
                owed_results.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("double_ended_queue_top_test failed");
                $finish;
            end
        end
    end

    // Drive items in bursts with random gaps
    initial
    begin
        int burst_left;
        int gap;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        row_typed = 1'b0;
        row_want  = '0;
        burst_left = 0;
        build_rows();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < rows.size(); k++)
        begin
            // Start a new burst, idling first unless the gap is empty
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            start     <= 1'b1;
            cmd       <= rows[k].item;
            row_typed <= rows[k].typed;
            row_want  <= rows[k].want;
            // Hold the item until the block takes it
            @(posedge clk);
            while (busy) @(posedge clk);
        end
        start <= 1'b0;

        // Drain the owed results, then let the block settle
        while (owed_results.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("double_ended_queue_top_test passed");
        else
            $display("double_ended_queue_top_test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue_top.sv
rtl/deq_checker.sv
tb/double_ended_queue_top_test.sv
